FILE: src/text_console_char_writer_top_assert.svh
// Assertion macros for the console writer.
// TCCW_ASSERT_IMP: same-cycle implication. TCCW_ASSERT_NXT: next-cycle implication.
`ifndef TEXT_CONSOLE_CHAR_WRITER_TOP_ASSERT_SVH
`define TEXT_CONSOLE_CHAR_WRITER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define TCCW_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tccw: same-cycle check failed");
`define TCCW_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tccw: next-cycle check failed");
`else
`define TCCW_ASSERT_IMP(name, ante, cons)
`define TCCW_ASSERT_NXT(name, ante, cons)
`endif
`endif

FILE: src/tccw_pkg.sv
package tccw_pkg;

  localparam int COLUMNS      = 80;
  localparam int ROWS         = 25;
  localparam int TERMINALS    = 3;
  localparam int SCREEN_CELLS = ROWS * COLUMNS;
  localparam int CELLS        = TERMINALS * SCREEN_CELLS;
  localparam int ADDR_W       = $clog2(CELLS);

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int TERM_W = 2;
  localparam int CHAR_W = 8;
  localparam int HW_W   = 11;
  localparam int CELL_W = 16;

  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;
  localparam logic [CHAR_W-1:0] RESET_ATTR = 8'd7;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_FILL = 1'b0;
  localparam logic REG_DISP = 1'b1;

  typedef logic [COL_W-1:0]  col_t;
  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [ADDR_W-1:0] addr_t;

endpackage

FILE: src/text_console_char_writer_top.sv
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tuser op; tdata terminal, char, row, col
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata cell, cursor, hw cursor, scrolled
// apb       in   psel/penable/pwrite, pready  fill_attribute @0, displayed_terminal @4
//
// Item: accept, then the address, memory and output states to the result register; no
// new word is accepted until the result is loaded. A put that scrolls also passes a clear
// state that writes the 80 cells of the cleared row one at a time (single write port).
// Scroll rotates a per-terminal top-row offset instead of moving cells.
// After reset a clearing pass writes all 6000 cells; no word is accepted until it ends.
// The next word is accepted while the previous result waits in the output register.
`include "text_console_char_writer_top_assert.svh"

module text_console_char_writer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] terminal, [9:2] char_code, [14:10] read_row, [21:15] read_col, [23:22] zero
  input  logic [23:0] s_axis_tdata,
  // [0] op
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] cell_char, [15:8] cell_attr, [22:16] cursor_col, [27:23] cursor_row,
  // [38:28] hw_cursor_pos, [39] scrolled
  output logic [39:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_ADDR = 3'd2;
  localparam logic [2:0] S_MEM  = 3'd3;
  localparam logic [2:0] S_CLR  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_q, state_d;

  tccw_pkg::addr_t init_cnt_q;
  tccw_pkg::col_t  clr_cnt_q;

  logic [7:0]                    fill_q;
  logic [tccw_pkg::TERM_W-1:0]   disp_q;

  tccw_pkg::col_t cur_col_q [tccw_pkg::TERMINALS];
  tccw_pkg::row_t cur_row_q [tccw_pkg::TERMINALS];
  tccw_pkg::row_t top_q     [tccw_pkg::TERMINALS];

  // captured word
  logic                          op_q;
  logic [tccw_pkg::TERM_W-1:0]   term_q;
  logic [tccw_pkg::CHAR_W-1:0]   char_q;
  tccw_pkg::row_t                rrow_q;
  tccw_pkg::col_t                rcol_q;

  // address stage results
  tccw_pkg::addr_t addr_q, addr_d;
  tccw_pkg::addr_t clr_base_q, clr_base_d;
  tccw_pkg::col_t  ncol_q, ncol_d;
  tccw_pkg::row_t  nrow_q, nrow_d;
  logic            scroll_q, scroll_d;
  logic            wr_q, wr_d;
  logic            rd_ok_q, rd_ok_d;

  logic            m_valid_q;
  logic [39:0]     m_data_q;

  logic                          in_acc;
  logic                          term_ok;
  logic                          disp_ok;
  logic                          cfg_wr;
  tccw_pkg::col_t                cc;
  tccw_pkg::row_t                cr;
  tccw_pkg::row_t                tp;
  tccw_pkg::row_t                lrow;
  tccw_pkg::col_t                lcol;
  logic [tccw_pkg::ROW_W:0]      psum;
  tccw_pkg::row_t                prow;
  tccw_pkg::addr_t               term_base;
  logic [tccw_pkg::COL_W:0]      col_inc;
  logic [tccw_pkg::ROW_W:0]      row_inc;
  logic [tccw_pkg::ROW_W:0]      nrow_raw;
  logic                          is_nl;
  logic                          is_cr;
  logic                          out_load;
  logic [tccw_pkg::HW_W-1:0]     hw_pos;
  logic [tccw_pkg::CELL_W-1:0]   cell_word;
  logic [tccw_pkg::CELL_W-1:0]   ram_rdata;
  logic                          ram_we;
  tccw_pkg::addr_t               ram_waddr;
  logic [tccw_pkg::CELL_W-1:0]   ram_wdata;
  logic                          ram_re;
  logic                          put_done;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign term_ok       = 32'(term_q) < tccw_pkg::TERMINALS;
  assign disp_ok       = 32'(disp_q) < tccw_pkg::TERMINALS;
  assign out_load      = (state_q == S_OUT) && (!m_valid_q || m_axis_tready);
  assign put_done      = (state_q == S_MEM) && term_ok && (op_q == tccw_pkg::OP_PUT);

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[2])
      tccw_pkg::REG_FILL: prdata = {24'd0, fill_q};
      tccw_pkg::REG_DISP: prdata = {30'd0, disp_q};
      default:            prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= tccw_pkg::RESET_ATTR;
      disp_q <= '0;
    end else if (cfg_wr) begin
      case (paddr[2])
        tccw_pkg::REG_FILL: fill_q <= pwdata[7:0];
        tccw_pkg::REG_DISP: disp_q <= pwdata[tccw_pkg::TERM_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- address and cursor step ----------------
  always_comb begin
    cc   = cur_col_q[term_q];
    cr   = cur_row_q[term_q];
    tp   = top_q[term_q];
    lrow = (op_q == tccw_pkg::OP_READ) ? rrow_q : cr;
    lcol = (op_q == tccw_pkg::OP_READ) ? rcol_q : cc;

    // logical row to physical row through the rotating top offset
    psum = {1'b0, lrow} + {1'b0, tp};
    prow = (32'(psum) >= tccw_pkg::ROWS) ?
           tccw_pkg::ROW_W'(32'(psum) - tccw_pkg::ROWS) : psum[tccw_pkg::ROW_W-1:0];

    term_base  = tccw_pkg::ADDR_W'(32'(term_q) * tccw_pkg::SCREEN_CELLS);
    addr_d     = term_base +
                 tccw_pkg::ADDR_W'(32'(prow) * tccw_pkg::COLUMNS + 32'(lcol));
    clr_base_d = term_base + tccw_pkg::ADDR_W'(32'(tp) * tccw_pkg::COLUMNS);

    rd_ok_d = (32'(rrow_q) < tccw_pkg::ROWS) && (32'(rcol_q) < tccw_pkg::COLUMNS);

    is_nl   = (char_q == tccw_pkg::CH_NEWLINE);
    is_cr   = (char_q == tccw_pkg::CH_RETURN);
    col_inc = {1'b0, cc} + 1'b1;
    row_inc = {1'b0, cr} + 1'b1;
    wr_d    = !is_nl && !is_cr;

    if (is_nl) begin
      ncol_d   = '0;
      nrow_raw = row_inc;
    end else if (is_cr) begin
      ncol_d   = '0;
      nrow_raw = {1'b0, cr};
    end else if (32'(col_inc) >= tccw_pkg::COLUMNS) begin
      ncol_d   = '0;
      nrow_raw = row_inc;
    end else begin
      ncol_d   = col_inc[tccw_pkg::COL_W-1:0];
      nrow_raw = {1'b0, cr};
    end

    scroll_d = 32'(nrow_raw) >= tccw_pkg::ROWS;
    nrow_d   = scroll_d ? tccw_pkg::ROW_W'(tccw_pkg::ROWS - 1)
                        : nrow_raw[tccw_pkg::ROW_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= s_axis_tuser;
      term_q <= s_axis_tdata[1:0];
      char_q <= s_axis_tdata[9:2];
      rrow_q <= s_axis_tdata[14:10];
      rcol_q <= s_axis_tdata[21:15];
    end
    if (state_q == S_ADDR) begin
      addr_q     <= addr_d;
      clr_base_q <= clr_base_d;
      ncol_q     <= ncol_d;
      nrow_q     <= nrow_d;
      scroll_q   <= scroll_d;
      wr_q       <= wr_d;
      rd_ok_q    <= rd_ok_d;
    end
  end

  // ---------------- cursors and top offsets ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < tccw_pkg::TERMINALS; i++) begin
        cur_col_q[i] <= '0;
        cur_row_q[i] <= '0;
        top_q[i]     <= '0;
      end
    end else if (put_done) begin
      for (int i = 0; i < tccw_pkg::TERMINALS; i++) begin
        if (term_q == tccw_pkg::TERM_W'(i)) begin
          cur_col_q[i] <= ncol_q;
          cur_row_q[i] <= nrow_q;
          if (scroll_q) begin
            top_q[i] <= (32'(top_q[i]) == tccw_pkg::ROWS - 1) ? '0 : top_q[i] + 1'b1;
          end
        end
      end
    end
  end

  // ---------------- cell store ----------------
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_q;
    ram_wdata = {fill_q, char_q};
    ram_re    = 1'b0;
    case (state_q)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = init_cnt_q;
        ram_wdata = {tccw_pkg::RESET_ATTR, tccw_pkg::CH_SPACE};
      end
      S_MEM: begin
        ram_we = put_done && wr_q;
        ram_re = term_ok && (op_q == tccw_pkg::OP_READ) && rd_ok_q;
      end
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_base_q + tccw_pkg::ADDR_W'(clr_cnt_q);
        ram_wdata = {fill_q, tccw_pkg::CH_SPACE};
      end
      default: ;
    endcase
  end

  tccw_ram #(
    .WIDTH (tccw_pkg::CELL_W),
    .DEPTH (tccw_pkg::CELLS)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_INIT: begin
        if (init_cnt_q == tccw_pkg::ADDR_W'(tccw_pkg::CELLS - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) state_d = S_ADDR;
      end
      S_ADDR: state_d = S_MEM;
      S_MEM: begin
        state_d = (put_done && scroll_q) ? S_CLR : S_OUT;
      end
      S_CLR: begin
        if (32'(clr_cnt_q) == tccw_pkg::COLUMNS - 1) state_d = S_OUT;
      end
      S_OUT: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_INIT;
      init_cnt_q <= '0;
      clr_cnt_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_INIT) init_cnt_q <= init_cnt_q + 1'b1;
      if (state_q == S_CLR) begin
        clr_cnt_q <= (32'(clr_cnt_q) == tccw_pkg::COLUMNS - 1) ? '0 : clr_cnt_q + 1'b1;
      end
    end
  end

  // ---------------- result register ----------------
  assign hw_pos = disp_ok ?
                  tccw_pkg::HW_W'(32'(cur_row_q[disp_q]) * tccw_pkg::COLUMNS +
                                  32'(cur_col_q[disp_q])) : '0;
  assign cell_word = (term_ok && (op_q == tccw_pkg::OP_READ) && rd_ok_q) ? ram_rdata : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= {term_ok && (op_q == tccw_pkg::OP_PUT) && scroll_q,
                   hw_pos,
                   term_ok ? cur_row_q[term_q] : tccw_pkg::row_t'(0),
                   term_ok ? cur_col_q[term_q] : tccw_pkg::col_t'(0),
                   cell_word};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // ---------------- checks ----------------
  `TCCW_ASSERT_NXT(a_accept_to_addr, in_acc, state_q == S_ADDR)
  `TCCW_ASSERT_IMP(a_wr_in_range, ram_we, 32'(ram_waddr) < tccw_pkg::CELLS)
  `TCCW_ASSERT_IMP(a_clr_cnt_range, state_q == S_CLR, 32'(clr_cnt_q) < tccw_pkg::COLUMNS)
  `TCCW_ASSERT_IMP(a_cursor_range, (state_q == S_OUT) && term_ok,
                   (32'(cur_col_q[term_q]) < tccw_pkg::COLUMNS) &&
                   (32'(cur_row_q[term_q]) < tccw_pkg::ROWS))
  `TCCW_ASSERT_NXT(a_scroll_last_row, put_done && scroll_q,
                   32'(cur_row_q[term_q]) == tccw_pkg::ROWS - 1)

endmodule

FILE: src/tccw_ram.sv
module tccw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 6000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import tccw_pkg::*;

  localparam int IDLE_LIMIT = 20000;  // clearing pass after reset writes all 6000 cells
  localparam logic [2:0] ADDR_FILL = {REG_FILL, 2'b00};
  localparam logic [2:0] ADDR_DISP = {REG_DISP, 2'b00};

  typedef struct packed {
    logic       op;
    logic [1:0] terminal;
    logic [7:0] char_code;
    row_t       read_row;
    col_t       read_col;
  } console_word_t;

  typedef struct packed {
    logic        scrolled;
    logic [10:0] hw_pos;
    row_t        cursor_row;
    col_t        cursor_col;
    logic [7:0]  cell_attr;
    logic [7:0]  cell_char;
  } cell_report_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [39:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  text_console_char_writer_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #6 clk_i = ~clk_i;

  // shadow of the console: cells are {attr, char}
  logic [15:0] screen [TERMINALS][ROWS][COLUMNS];
  col_t        cur_col [TERMINALS];
  row_t        cur_row [TERMINALS];
  logic [7:0]  fill_attr_q = RESET_ATTR;
  logic [1:0]  disp_term_q = '0;

  console_word_t words_to_send[$];
  cell_report_t  expected_reports[$];

  int  mismatch_count = 0;
  int  put_count = 0;
  int  read_count = 0;
  int  scroll_count = 0;
  int  wrap_count = 0;
  int  checked_count = 0;
  int  send_gap = 0;
  int  recv_wait = 0;
  int  idle_cycles = 0;
  bit  steady = 1'b0;

  function automatic int draw_wait();
    return steady ? 0 : int'($urandom_range(0, 15));
  endfunction

  function automatic cell_report_t console_step(input logic op, input logic [1:0] term,
                                                input logic [7:0] ch, input row_t rr,
                                                input col_t rc);
    cell_report_t r;
    int col;
    int row;
    r = '0;
    if (term < TERMINALS) begin
      if (op == OP_PUT) begin
        put_count++;
        col = int'(cur_col[term]);
        row = int'(cur_row[term]);
        if (ch == CH_NEWLINE) begin
          col = 0;
          row++;
        end else if (ch == CH_RETURN) begin
          col = 0;
        end else begin
          screen[term][row][col] = {fill_attr_q, ch};
          col++;
          if (col >= COLUMNS) begin
            col = 0;
            row++;
            wrap_count++;
          end
        end
        if (row >= ROWS) begin
          for (int y = 0; y < ROWS - 1; y++) screen[term][y] = screen[term][y + 1];
          for (int x = 0; x < COLUMNS; x++) screen[term][ROWS - 1][x] = {fill_attr_q, CH_SPACE};
          col = 0;
          row = ROWS - 1;
          r.scrolled = 1'b1;
          scroll_count++;
        end
        cur_col[term] = col_t'(col);
        cur_row[term] = row_t'(row);
      end else begin
        read_count++;
        if (rr < ROWS && rc < COLUMNS) {r.cell_attr, r.cell_char} = screen[term][rr][rc];
      end
      r.cursor_col = cur_col[term];
      r.cursor_row = cur_row[term];
    end
    if (disp_term_q < TERMINALS)
      r.hw_pos = 11'(cur_row[disp_term_q] * COLUMNS + cur_col[disp_term_q]);
    return r;
  endfunction

  // driver
  always @(posedge clk_i) begin : drive_words
    console_word_t w;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_reports.push_back(console_step(s_axis_tuser, s_axis_tdata[1:0],
                                                s_axis_tdata[9:2], s_axis_tdata[14:10],
                                                s_axis_tdata[21:15]));
        if ($urandom_range(0, 39) == 0) steady <= !steady;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap != 0) begin
          s_axis_tvalid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (words_to_send.size() != 0) begin
          w = words_to_send.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= w.op;
          s_axis_tdata  <= {2'b00, w.read_col, w.read_row, w.char_code, w.terminal};
          send_gap <= draw_wait();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor and checker
  always @(posedge clk_i) begin : check_reports
    cell_report_t got;
    cell_report_t want;
    int w;
    if (!rst_ni) begin
      m_axis_tready <= 1'b1;
      recv_wait <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      checked_count++;
      if (expected_reports.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("[%0t] unexpected word: char %0d attr %0d col %0d row %0d hw %0d scr %0d",
                   $realtime, got.cell_char, got.cell_attr, got.cursor_col, got.cursor_row,
                   got.hw_pos, got.scrolled);
      end else begin
        want = expected_reports.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("[%0t] word mismatch: exp char %0d attr %0d col %0d row %0d hw %0d scr %0d",
                     $realtime, want.cell_char, want.cell_attr, want.cursor_col,
                     want.cursor_row, want.hw_pos, want.scrolled);
            $display("[%0t]                got char %0d attr %0d col %0d row %0d hw %0d scr %0d",
                     $realtime, got.cell_char, got.cell_attr, got.cursor_col,
                     got.cursor_row, got.hw_pos, got.scrolled);
          end
        end
      end
      w = draw_wait();
      m_axis_tready <= (w == 0);
      recv_wait <= w;
    end else if (m_axis_tvalid && !m_axis_tready) begin
      // stall counts only while a word is waiting
      if (recv_wait <= 1) m_axis_tready <= 1'b1;
      if (recv_wait > 0) recv_wait <= recv_wait - 1;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_register(input logic [2:0] addr, input logic [31:0] value);
    logic [31:0] rd;
    apb_access(1'b0, addr, '0, rd);
    if (rd !== value) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("[%0t] register @%0d: exp %0h got %0h", $realtime, addr, value, rd);
    end
  endtask

  task automatic set_register(input logic [2:0] addr, input logic [31:0] value);
    logic [31:0] rd;
    apb_access(1'b1, addr, value, rd);
    if (addr == ADDR_FILL) fill_attr_q = value[7:0];
    else disp_term_q = value[1:0];
    check_register(addr, value);
  endtask

  function automatic console_word_t mk_word(input logic op, input logic [1:0] term,
                                            input logic [7:0] ch, input row_t rr,
                                            input col_t rc);
    console_word_t w;
    w.op = op;
    w.terminal = term;
    w.char_code = ch;
    w.read_row = rr;
    w.read_col = rc;
    return w;
  endfunction

  function automatic logic [7:0] printable_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CH_NEWLINE || c == CH_RETURN);
    return c;
  endfunction

  function automatic logic [1:0] live_terminal();
    return 2'($urandom_range(0, TERMINALS - 1));
  endfunction

  // lines of text with random lengths (some long enough to wrap), reads, and noise
  task automatic queue_random_traffic(input int n);
    int made;
    int len;
    int kind;
    logic [1:0] term;
    console_word_t w;
    made = 0;
    while (made < n) begin
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        term = live_terminal();
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 170) : $urandom_range(0, 20);
        for (int k = 0; k < len; k++)
          words_to_send.push_back(mk_word(OP_PUT, term, printable_char(),
                                          row_t'($urandom), col_t'($urandom)));
        made += len;
        case ($urandom_range(0, 3))
          0, 1: begin
            words_to_send.push_back(mk_word(OP_PUT, term, CH_NEWLINE,
                                            row_t'($urandom), col_t'($urandom)));
            made++;
          end
          2: begin
            words_to_send.push_back(mk_word(OP_PUT, term, CH_RETURN,
                                            row_t'($urandom), col_t'($urandom)));
            made++;
          end
          default: ;
        endcase
      end else if (kind < 9) begin
        len = $urandom_range(1, 4);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 7) == 0)
            w = mk_word(OP_READ, live_terminal(), 8'($urandom), row_t'($urandom),
                        col_t'($urandom));
          else
            w = mk_word(OP_READ, live_terminal(), 8'($urandom),
                        row_t'($urandom_range(0, ROWS - 1)),
                        col_t'($urandom_range(0, COLUMNS - 1)));
          words_to_send.push_back(w);
        end
        made += len;
      end else begin
        w = 23'($urandom);
        words_to_send.push_back(w);
        if (w.terminal < TERMINALS) made++;
      end
    end
  endtask

  task automatic drain();
    while (words_to_send.size() != 0 || s_axis_tvalid || expected_reports.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [7:0] fills [4];
    logic [1:0] disps [4];
    for (int t = 0; t < TERMINALS; t++) begin
      cur_col[t] = '0;
      cur_row[t] = '0;
      for (int y = 0; y < ROWS; y++)
        for (int x = 0; x < COLUMNS; x++) screen[t][y][x] = {RESET_ATTR, CH_SPACE};
    end
    fills[0] = 8'hFF;
    fills[1] = 8'h00;
    fills[2] = 8'($urandom);
    fills[3] = 8'($urandom);
    disps[0] = 2'd1;
    disps[1] = 2'd2;
    disps[2] = 2'd3;   // no such terminal: hardware cursor reads 0
    disps[3] = 2'd0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    check_register(ADDR_FILL, {24'd0, RESET_ATTR});
    check_register(ADDR_DISP, 32'd0);

    // reset contents, screen corners, reads off the screen, control bytes,
    // byte extremes, and a terminal that does not exist
    words_to_send.push_back(mk_word(OP_READ, 2'd0, 8'h00, 5'd0, 7'd0));
    words_to_send.push_back(mk_word(OP_READ, 2'd2, 8'hFF, 5'd24, 7'd79));
    words_to_send.push_back(mk_word(OP_READ, 2'd1, 8'h00, 5'd31, 7'd127));
    words_to_send.push_back(mk_word(OP_READ, 2'd0, 8'h00, 5'd25, 7'd0));
    words_to_send.push_back(mk_word(OP_READ, 2'd0, 8'h00, 5'd0, 7'd80));
    words_to_send.push_back(mk_word(OP_PUT, 2'd0, 8'h00, 5'd31, 7'd127));
    words_to_send.push_back(mk_word(OP_PUT, 2'd0, 8'hFF, 5'd0, 7'd0));
    words_to_send.push_back(mk_word(OP_PUT, 2'd0, "A", 5'd0, 7'd0));
    words_to_send.push_back(mk_word(OP_PUT, 2'd0, CH_RETURN, 5'd0, 7'd0));
    words_to_send.push_back(mk_word(OP_READ, 2'd0, 8'h00, 5'd0, 7'd0));
    words_to_send.push_back(mk_word(OP_PUT, 2'd0, CH_NEWLINE, 5'd0, 7'd0));
    words_to_send.push_back(mk_word(OP_PUT, 2'd1, "z", 5'd0, 7'd0));
    words_to_send.push_back(mk_word(OP_PUT, 2'd3, "Q", 5'd0, 7'd0));
    words_to_send.push_back(mk_word(OP_READ, 2'd3, 8'h00, 5'd0, 7'd0));
    words_to_send.push_back(mk_word(OP_PUT, 2'd2, CH_NEWLINE, 5'd0, 7'd0));
    words_to_send.push_back(mk_word(OP_READ, 2'd0, 8'h00, 5'd0, 7'd1));
    words_to_send.push_back(mk_word(OP_PUT, 2'd0, 8'hAA, 5'd21, 7'd42));
    words_to_send.push_back(mk_word(OP_PUT, 2'd0, 8'h55, 5'd10, 7'd85));
    words_to_send.push_back(mk_word(OP_READ, 2'd0, 8'h00, 5'd1, 7'd0));
    words_to_send.push_back(mk_word(OP_READ, 2'd1, 8'h00, 5'd0, 7'd0));
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      set_register(ADDR_FILL, {24'd0, fills[ph]});
      set_register(ADDR_DISP, {30'd0, disps[ph]});
      queue_random_traffic(350);
      drain();
    end
    repeat (100) @(posedge clk_i);

    mismatch_count += expected_reports.size();
    $display("run covered %0d puts (%0d row wraps, %0d scrolls) and %0d cell reads",
             put_count, wrap_count, scroll_count, read_count);
    $display("%0d words checked across 5 register settings, %0d mismatches",
             checked_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
